// File: hw/rtl/phb_pkg.sv
// ----------------------------------------------------------------------------
// phb_pkg: shared types and constants of the host bridge configuration space
// Word layouts, action codes, register offsets and routing constants.
// ----------------------------------------------------------------------------
package phb_pkg;

  localparam int unsigned VARIANT_W = 3;
  localparam int unsigned PAM_NUM   = 7;

  // chip generation codes
  localparam logic [VARIANT_W-1:0] VAR_MID    = 3'd2;
  localparam logic [VARIANT_W-1:0] VAR_BOARD  = 3'd3;
  localparam logic [VARIANT_W-1:0] VAR_LATE   = 3'd4;
  localparam logic [VARIANT_W-1:0] VAR_NEWEST = 3'd6;
  localparam logic [VARIANT_W-1:0] VAR_SPARE  = 3'd7;

  typedef enum logic [1:0] {
    ACT_READ       = 2'd0,
    ACT_WRITE      = 2'd1,
    ACT_LOAD       = 2'd2,
    ACT_SOFT_RESET = 2'd3
  } action_e;

  // register offsets
  localparam logic [7:0] ADDR_CMD_LO    = 8'h04;
  localparam logic [7:0] ADDR_CMD_HI    = 8'h05;
  localparam logic [7:0] ADDR_STS_LO    = 8'h06;
  localparam logic [7:0] ADDR_STS_HI    = 8'h07;
  localparam logic [7:0] ADDR_LOCK_LO   = 8'h10;
  localparam logic [7:0] ADDR_LOCK_HI   = 8'h4e;
  localparam logic [7:0] ADDR_CACHE_CTL = 8'h52;
  localparam logic [7:0] ADDR_PAM0      = 8'h59;
  localparam logic [7:0] ADDR_PAM1      = 8'h5a;
  localparam logic [7:0] ADDR_PAM6      = 8'h5f;
  localparam logic [7:0] ADDR_SMRAM     = 8'h72;

  // region constants
  localparam logic [19:0] BIOS_BASE   = 20'hf0000;
  localparam logic [17:0] BIOS_SIZE   = 18'h10000;
  localparam logic [19:0] PAM_BASE    = 20'hc0000;
  localparam logic [17:0] PAM_SIZE    = 18'h04000;
  localparam logic [19:0] SMRAM_BASE  = 20'ha0000;
  localparam logic [17:0] SMRAM_SIZE  = 18'h20000;
  localparam logic [7:0]  SMRAM_OPEN  = 8'h48;
  localparam logic [7:0]  SMRAM_RESET = 8'h02;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] function_number;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        map_valid;
    logic [19:0] map_base;
    logic [17:0] map_size;
    logic        read_internal;
    logic        write_internal;
    logic        shadow_bios;
    logic        ext_cache_enable;
    logic        last;
  } out_t;

  // one or two result words offered by the core
  typedef struct packed {
    logic valid;
    logic two;
    out_t first;
    out_t second;
  } res_pair_t;

endpackage

// File: hw/rtl/phb_ram.sv
// ----------------------------------------------------------------------------
// phb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module phb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/phb_core.sv
// ----------------------------------------------------------------------------
// phb_core: input register, configuration store and access decode
// Holds one access word, reads the byte store, applies the write masks and
// works out the region mapping words and flags in a single pass.
// ----------------------------------------------------------------------------
module phb_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  phb_pkg::in_t                   in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [phb_pkg::VARIANT_W-1:0]  cfg_data_i,
  output phb_pkg::res_pair_t             req_o,
  input  logic                           take_i
);
  import phb_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [19:0] base;
    logic [17:0] size;
    logic [1:0]  route;
  } map_t;

  // reset contents after a default load, per chip generation
  function automatic logic [7:0] default_byte(logic [VARIANT_W-1:0] chip, logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    unique case (a)
      8'h00: r = 8'h86;
      8'h01: r = 8'h80;
      8'h02: r = (chip <= 3'd1) ? 8'ha3 : (chip <= VAR_BOARD) ? 8'h2d :
                 (chip == VAR_LATE) ? 8'h50 : (chip == 3'd5) ? 8'h30 : 8'h37;
      8'h03: r = (chip <= 3'd1) ? 8'h04 : (chip == 3'd5) ? 8'h70 : 8'h12;
      8'h04: r = 8'h06;
      8'h06: r = (chip == VAR_NEWEST) ? 8'h80 : 8'h00;
      8'h07: r = (chip == VAR_MID) ? 8'h82 : (chip == VAR_NEWEST) ? 8'h00 : 8'h02;
      8'h08: r = (chip == 3'd0) ? 8'h03 : (chip == 3'd1) ? 8'h10 :
                 (chip == VAR_BOARD || chip == VAR_NEWEST) ? 8'h02 : 8'h00;
      8'h0b: r = 8'h06;
      8'h2c: r = (chip == VAR_NEWEST) ? 8'hf4 : 8'h00;
      8'h2d: r = (chip == VAR_NEWEST) ? 8'h1a : 8'h00;
      8'h2f: r = (chip == VAR_NEWEST) ? 8'h11 : 8'h00;
      8'h50: r = (chip == 3'd0) ? 8'h80 : (chip == 3'd1) ? 8'ha0 : 8'h00;
      8'h51: r = (chip == VAR_LATE) ? 8'h20 : (chip == VAR_NEWEST) ? 8'h01 : 8'h00;
      8'h52: r = (chip == 3'd1) ? 8'h44 : (chip == VAR_LATE) ? 8'hb5 :
                 (chip == 3'd5) ? 8'h42 : (chip == VAR_NEWEST) ? 8'h00 : 8'h40;
      8'h53: r = (chip == 3'd5) ? 8'h14 : (chip == VAR_NEWEST) ? 8'h80 : 8'h00;
      8'h56: r = (chip == VAR_LATE || chip == 3'd5) ? 8'h52 : 8'h00;
      8'h57: r = (chip >= VAR_MID) ? 8'h01 : 8'h31;
      8'h58: r = (chip == VAR_NEWEST) ? 8'h10 : 8'h00;
      8'h59: r = (chip == VAR_LATE) ? 8'h40 : 8'h00;
      8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e:
             r = (chip == VAR_LATE) ? 8'h44 : (chip == VAR_NEWEST) ? 8'h11 : 8'h00;
      8'h5f: r = (chip == VAR_LATE) ? 8'h44 : (chip == VAR_NEWEST) ? 8'h31 : 8'h00;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64:
             r = 8'h02;
      8'h65: r = (chip == VAR_LATE) ? 8'h02 : 8'h00;
      8'h66: r = (chip == 3'd1 || chip == VAR_LATE) ? 8'h02 : 8'h00;
      8'h67: r = (chip == 3'd1 || chip == VAR_LATE) ? 8'h02 :
                 (chip == 3'd5) ? 8'h11 : 8'h00;
      8'h68: r = (chip == VAR_LATE) ? 8'h11 : 8'h00;
      8'h69: r = (chip == 3'd5) ? 8'h03 : 8'h00;
      8'h70: r = (chip == 3'd5) ? 8'h20 : 8'h00;
      8'h72: r = (chip >= VAR_MID) ? 8'h02 : 8'h00;
      8'h74: r = (chip == 3'd5) ? 8'h0e : 8'h00;
      8'h78: r = (chip == 3'd5) ? 8'h23 : 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // offsets that ignore writes: identification bytes and the locked window
  function automatic logic is_locked(logic [7:0] a);
    logic l;
    l = 1'b0;
    unique case (a)
      8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0e:
        l = 1'b1;
      default:
        l = (a >= ADDR_LOCK_LO) && (a <= ADDR_LOCK_HI);
    endcase
    return l;
  endfunction

  // write masks for command and status bytes
  function automatic logic [7:0] masked_value(logic [VARIANT_W-1:0] chip, logic [7:0] a,
                                              logic [7:0] v);
    logic [7:0] r;
    r = v;
    unique case (a)
      ADDR_CMD_LO: begin
        if (chip >= VAR_MID) begin
          r = v & ((chip == VAR_BOARD) ? 8'h06 : 8'h02);
        end else begin
          r = v & 8'h42;
        end
        r = r | 8'h04;
      end
      ADDR_CMD_HI: r = (chip >= VAR_MID) ? 8'h00 : (v & 8'h01);
      ADDR_STS_LO: r = 8'h00;
      ADDR_STS_HI: begin
        if (chip >= VAR_LATE) begin
          r = (v & 8'h80) | 8'h02;
        end else begin
          r = (chip == VAR_BOARD) ? 8'h22 : 8'h02;
        end
      end
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic out_t make_word(map_t m, logic [7:0] rd, logic bios, logic ext,
                                     logic lst);
    out_t w;
    w.read_data        = rd;
    w.map_valid        = m.valid;
    w.map_base         = m.valid ? m.base : '0;
    w.map_size         = m.valid ? m.size : '0;
    w.read_internal    = m.valid & m.route[0];
    w.write_internal   = m.valid & m.route[1];
    w.shadow_bios      = bios;
    w.ext_cache_enable = ext;
    w.last             = lst;
    return w;
  endfunction

  in_t                   in_q;
  logic                  in_vld_q;
  logic [VARIANT_W-1:0]  chip_q;
  logic                  loaded_q;
  logic [VARIANT_W-1:0]  ldvar_q;
  logic [255:0]          vld_q;
  logic [7:0]            pam_q [PAM_NUM];
  logic [7:0]            smram_q;
  logic                  bios_q;
  logic                  ext_q;
  logic                  byp_q;
  logic [7:0]            byp_data_q;
  logic [7:0]            ram_rdata;

  logic [VARIANT_W-1:0]  chip;
  logic                  accept;
  logic                  commit;
  logic                  fn_zero;
  logic                  do_write;
  logic                  is_pam;
  logic                  is_smram;
  logic [2:0]            pam_idx;
  logic [2:0]            blk_idx;
  logic [19:0]           blk_base;
  logic [7:0]            wval;
  logic [7:0]            old_shadow;
  logic [7:0]            diff;
  logic                  ram_we;
  logic                  bios_d;
  logic                  ext_d;
  logic [7:0]            rd_byte;
  logic [7:0]            rd_data;
  map_t                  map_a;
  map_t                  map_b;
  map_t                  map_first;

  // handshakes
  assign chip        = (chip_q == VAR_SPARE) ? VAR_NEWEST : chip_q;
  assign commit      = in_vld_q & take_i;
  assign in_stall_o  = in_vld_q & ~take_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // access decode
  assign fn_zero  = (in_q.function_number == '0);
  assign is_pam   = (in_q.reg_addr >= ADDR_PAM0) && (in_q.reg_addr <= ADDR_PAM6);
  assign is_smram = (in_q.reg_addr == ADDR_SMRAM);
  assign pam_idx  = 3'(in_q.reg_addr - ADDR_PAM0);
  assign blk_idx  = 3'(in_q.reg_addr - ADDR_PAM1);
  assign blk_base = PAM_BASE + {2'b00, blk_idx, 15'h0000};
  assign do_write = (in_q.action == ACT_WRITE) && fn_zero && !is_locked(in_q.reg_addr);
  assign wval     = masked_value(chip, in_q.reg_addr, in_q.write_data);
  assign ram_we   = commit && do_write && !is_pam && !is_smram;

  always_comb begin
    if (is_smram) begin
      old_shadow = smram_q;
    end else if (is_pam) begin
      old_shadow = pam_q[pam_idx];
    end else begin
      old_shadow = 8'h00;
    end
  end
  assign diff = old_shadow ^ wval;

  // read path: shadow flops, written bytes, then defaults
  always_comb begin
    if (is_smram || is_pam) begin
      rd_byte = old_shadow;
    end else if (vld_q[in_q.reg_addr]) begin
      rd_byte = byp_q ? byp_data_q : ram_rdata;
    end else if (loaded_q) begin
      rd_byte = default_byte(ldvar_q, in_q.reg_addr);
    end else begin
      rd_byte = 8'h00;
    end
    if (in_q.action == ACT_READ) begin
      rd_data = fn_zero ? rd_byte : 8'hff;
    end else begin
      rd_data = 8'h00;
    end
  end

  // mapping words and flags
  always_comb begin
    map_a  = '0;
    map_b  = '0;
    bios_d = bios_q;
    ext_d  = ext_q;
    unique case (in_q.action)
      ACT_WRITE: begin
        if (do_write) begin
          if (in_q.reg_addr == ADDR_PAM0) begin
            if (diff[7:4] != 4'h0) begin
              map_a  = '{valid: 1'b1, base: BIOS_BASE, size: BIOS_SIZE,
                         route: wval[5:4]};
              bios_d = wval[4];
            end
          end else if (is_pam) begin
            map_a = '{valid: (diff[3:0] != 4'h0), base: blk_base, size: PAM_SIZE,
                      route: wval[1:0]};
            map_b = '{valid: (diff[7:4] != 4'h0), base: blk_base + 20'(PAM_SIZE),
                      size: PAM_SIZE, route: wval[5:4]};
          end else if (is_smram) begin
            if (chip >= VAR_MID && (diff & SMRAM_OPEN) != 8'h00) begin
              map_a = '{valid: 1'b1, base: SMRAM_BASE, size: SMRAM_SIZE,
                        route: ((wval & SMRAM_OPEN) == SMRAM_OPEN) ? 2'b11 : 2'b00};
            end
          end else if (in_q.reg_addr == ADDR_CACHE_CTL) begin
            if (chip != VAR_NEWEST) begin
              ext_d = wval[0];
            end
          end
        end
      end
      ACT_LOAD: begin
        if (chip == VAR_NEWEST) begin
          ext_d = 1'b1;
        end
      end
      ACT_SOFT_RESET: begin
        // clear PAM0, then put SMRAM back to its reset value
        if (pam_q[0][7:4] != 4'h0) begin
          map_a  = '{valid: 1'b1, base: BIOS_BASE, size: BIOS_SIZE, route: 2'b00};
          bios_d = 1'b0;
        end
        if (chip >= VAR_MID && ((smram_q ^ SMRAM_RESET) & SMRAM_OPEN) != 8'h00) begin
          map_b = '{valid: 1'b1, base: SMRAM_BASE, size: SMRAM_SIZE, route: 2'b00};
        end
      end
      default: begin
        map_a = '0;
      end
    endcase
  end

  assign map_first = map_a.valid ? map_a : map_b;

  always_comb begin
    req_o.valid  = in_vld_q;
    req_o.two    = map_a.valid & map_b.valid;
    req_o.first  = make_word(map_first, rd_data, bios_d, ext_d, ~(map_a.valid & map_b.valid));
    req_o.second = make_word(map_b, rd_data, bios_d, ext_d, 1'b1);
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
        byp_q    <= ram_we && (in_q.reg_addr == in_i.reg_addr);
      end else if (commit) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  // input word and forwarded write byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q       <= in_i;
      byp_data_q <= wval;
    end
  end

  // chip generation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      chip_q <= cfg_data_i;
    end
  end

  // architectural state updated once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      ldvar_q  <= '0;
      vld_q    <= '0;
      smram_q  <= 8'h00;
      bios_q   <= 1'b0;
      ext_q    <= 1'b0;
      for (int i = 0; i < PAM_NUM; i++) begin
        pam_q[i] <= 8'h00;
      end
    end else if (commit) begin
      bios_q <= bios_d;
      ext_q  <= ext_d;
      unique case (in_q.action)
        ACT_WRITE: begin
          if (ram_we) begin
            vld_q[in_q.reg_addr] <= 1'b1;
          end
          if (do_write && is_pam) begin
            pam_q[pam_idx] <= wval;
          end
          if (do_write && is_smram) begin
            smram_q <= wval;
          end
        end
        ACT_LOAD: begin
          loaded_q <= 1'b1;
          ldvar_q  <= chip;
          vld_q    <= '0;
          smram_q  <= default_byte(chip, ADDR_SMRAM);
          for (int i = 0; i < PAM_NUM; i++) begin
            pam_q[i] <= default_byte(chip, ADDR_PAM0 + 8'(i));
          end
        end
        ACT_SOFT_RESET: begin
          pam_q[0] <= 8'h00;
          if (chip >= VAR_MID) begin
            smram_q <= SMRAM_RESET;
          end
        end
        default: begin
          loaded_q <= loaded_q;
        end
      endcase
    end
  end

  // byte store for everything without side effects
  phb_ram #(
    .WIDTH (8),
    .DEPTH (256)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_q.reg_addr),
    .wdata_i (wval),
    .re_i    (accept),
    .raddr_i (in_i.reg_addr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: hw/rtl/phb_out.sv
// ----------------------------------------------------------------------------
// phb_out: result register with hold slot for a second mapping word
// Takes one or two words from the core and hands them out in order.
// ----------------------------------------------------------------------------
module phb_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  phb_pkg::res_pair_t req_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output phb_pkg::out_t      out_o
);
  import phb_pkg::*;

  out_t out_q;
  out_t hold_q;
  logic out_vld_q;
  logic hold_vld_q;
  logic slot_free;

  assign slot_free   = ~out_vld_q | ~out_stall_i;
  assign take_o      = slot_free & ~hold_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else if (slot_free) begin
      if (hold_vld_q) begin
        out_vld_q  <= 1'b1;
        hold_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= req_i.valid;
        hold_vld_q <= req_i.valid & req_i.two;
      end
    end
  end

  // words
  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (hold_vld_q) begin
        out_q <= hold_q;
      end else if (req_i.valid) begin
        out_q  <= req_i.first;
        hold_q <= req_i.second;
      end
    end
  end

endmodule

// File: hw/rtl/pci_host_bridge_config_space.sv
// ----------------------------------------------------------------------------
// pci_host_bridge_config_space: host bridge configuration space, function 0
// Byte-wide configuration register file with shadow region routing reports.
// ----------------------------------------------------------------------------
// Usage
//   in channel  : one access word (read, write, load defaults, soft reset)
//                 per accepted in_valid_i with in_stall_o low
//   out channel : one or two result words per access; last marks the final
//   cfg channel : chip generation code, to be written by the user only while the
//                 block is idle (the block does not enforce it); cfg_ready_o is always high
// Order: an accepted access is held in the input register, and its first
//   result word is then registered in the result register. Throughput: one
//   access per cycle while out_stall_i is low and it raises at most one
//   mapping word; a second word waits in the hold slot and holds back the next access.
// Reset: all bytes read as zero, flags and chip code clear; per-byte valid
//   flops make the store usable at once, with no clearing pass.
// Stall: while out_stall_i is high the result word holds, the pending
//   access stays in the input register and in_stall_o rises.
// ----------------------------------------------------------------------------
module pci_host_bridge_config_space (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  phb_pkg::in_t                  in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output phb_pkg::out_t                 out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [phb_pkg::VARIANT_W-1:0] cfg_data_i
);
  import phb_pkg::*;

  res_pair_t req;
  logic      take;

  // decode and state
  phb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .req_o       (req),
    .take_i      (take)
  );

  // result register
  phb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  // an offered pair waits unchanged until the result side takes it
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && !take |=> req.valid && $stable(req))
    else $error("result pair changed before it was taken");

  // a pair of words always carries two mapping changes
  a_two_maps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.two |-> req.first.map_valid && req.second.map_valid)
    else $error("second word offered without two mapping changes");

  // the first word is final exactly when no second word follows
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |-> (req.first.last != req.two))
    else $error("last marker disagrees with word count");
`endif

endmodule
